// ===== hdl/jwk_pkg.sv =====
// Shared types and constants for the jog wheel encoder and key core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package jwk_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_STEPS  = 2'd1,
    CMD_PRESS  = 2'd2,
    CMD_REPEAT = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_DIVIDE = 2'd0;
  localparam logic [1:0] CFG_REPEAT_DELAY    = 2'd1;
  localparam logic [1:0] CFG_REPEAT_PERIOD   = 2'd2;

  // Configuration reset values
  localparam logic [7:0] DEBOUNCE_DIVIDE_RST = 8'd10;
  localparam logic [7:0] REPEAT_DELAY_RST    = 8'd50;
  localparam logic [7:0] REPEAT_PERIOD_RST   = 8'd20;

  // Decoded item handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] phase;    // binary phase from the Gray-coded pins
    logic       pressed;  // button pin inverted, 1 = pressed
  } op_t;

  // One result item
  typedef struct packed {
    logic signed [6:0] steps_moved;
    logic              button_flag;
  } result_t;

endpackage

// ===== hdl/jog_wheel_encoder_and_key_core.sv =====
// Top level of the jog wheel encoder and key core.
// Depends on jwk_pkg, jwk_front, jwk_back and jwk_outq.
`timescale 1ns / 1ps

// Quadrature jog wheel decoder with a debounced, auto-repeating push button.
// Items enter through a queue-style port (in_push / in_full) and results leave
// through another (out_empty / out_pop). Command 0 is a 1 ms tick carrying the
// sampled A, B and active-low button pins and gives no result; commands 1, 2
// and 3 read the step count (arithmetically halved, bit 0 kept), the press
// latch and the repeat latch, each giving one result item. Throughput is one
// item per clock outside read stalls: the back end retires one item each
// cycle from a 2-entry decode queue, and results pass through a 2-entry
// queue, so a read result shows on the out_ ports in the cycle after its item
// is taken. Reads stall only while the result queue is full; ticks never stall.
// Configuration (index 0 debounce_divide, 1 repeat_delay, 2 repeat_period;
// index 3 is ignored) is written through cfg_we/cfg_index/cfg_data and
// should only change while the block is idle.

module jog_wheel_encoder_and_key_core (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  // input items
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_command,
  input  logic              in_pin_a,
  input  logic              in_pin_b,
  input  logic              in_pin_button,
  // result items
  output logic              out_empty,
  input  logic              out_pop,
  output logic signed [6:0] out_steps_moved,
  output logic              out_button_flag
);

  logic             op_valid;
  jwk_pkg::op_t     op;
  logic             op_pop;
  logic             res_full;
  logic             res_push;
  jwk_pkg::result_t res;

  // decode and queue incoming items
  jwk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_command   (in_command),
    .in_pin_a     (in_pin_a),
    .in_pin_b     (in_pin_b),
    .in_pin_button(in_pin_button),
    .op_valid     (op_valid),
    .op           (op),
    .op_pop       (op_pop)
  );

  // encoder, debounce and latch state; one item per cycle unless a read waits for room
  jwk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue, decouples the back end from the consumer
  jwk_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_push       (res_push),
    .res            (res),
    .res_full       (res_full),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_steps_moved(out_steps_moved),
    .out_button_flag(out_button_flag)
  );

  // A result comes only from a read item that is being retired
  a_push_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (op_valid && op_pop && (op.cmd != jwk_pkg::CMD_TICK)))
    else $error("result pushed without a read item");

  // The back end never overruns the result queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overrun");

  // A read item is retired exactly when it produces a result
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && (op.cmd != jwk_pkg::CMD_TICK)) |-> res_push)
    else $error("read item retired without a result");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

// ===== hdl/jwk_front.sv =====
// Front end: decodes input items and holds them in a 2-entry queue for the back end.
// Depends on jwk_pkg.
`timescale 1ns / 1ps

module jwk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_command,
  input  logic              in_pin_a,
  input  logic              in_pin_b,
  input  logic              in_pin_button,
  output logic              op_valid,
  output jwk_pkg::op_t      op,
  input  logic              op_pop
);

  jwk_pkg::op_t mem_r [2];
  jwk_pkg::op_t op_new;
  logic [1:0]   count_r, count_nxt;
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic         do_push, do_pop;

  assign in_full  = (count_r == 2'd2);
  assign op_valid = (count_r != 2'd0);
  assign op       = mem_r[rd_ptr_r];
  assign do_push  = in_push && !in_full;
  assign do_pop   = op_pop && op_valid;

  // Gray to binary: high bit is A, low bit is A xor B
  always_comb begin
    op_new.cmd     = jwk_pkg::cmd_t'(in_command);
    op_new.phase   = {in_pin_a, in_pin_a ^ in_pin_b};
    op_new.pressed = ~in_pin_button;
  end

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= op_new;
    end
  end

endmodule

// ===== hdl/jwk_back.sv =====
// Back end: encoder accumulator, button debounce, auto-repeat and read handling.
// Holds the configuration registers. Depends on jwk_pkg.
`timescale 1ns / 1ps

module jwk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              op_valid,
  input  jwk_pkg::op_t      op,
  output logic              op_pop,
  input  logic              res_full,
  output logic              res_push,
  output jwk_pkg::result_t  res
);

  logic [7:0] debounce_divide_r, repeat_delay_r, repeat_period_r;

  logic [1:0] last_phase_r, last_phase_nxt;
  logic [7:0] step_accum_r, step_accum_nxt;
  logic [7:0] sample_div_r, sample_div_nxt;
  logic       vert_low_r, vert_low_nxt;
  logic       vert_high_r, vert_high_nxt;
  logic       key_r, key_nxt;
  logic       press_latch_r, press_latch_nxt;
  logic       repeat_latch_r, repeat_latch_nxt;
  logic [7:0] repeat_count_r, repeat_count_nxt;

  logic       exec;
  logic [1:0] diff;
  logic [7:0] div_inc;
  logic       change, vl_n, vh_n, flip, key_n;
  logic [7:0] rc_base, rc_dec;

  // Ticks never stall; reads wait for room in the result queue
  assign exec   = op_valid && ((op.cmd == jwk_pkg::CMD_TICK) || !res_full);
  assign op_pop = exec;

  always_comb begin
    diff    = last_phase_r - op.phase;
    div_inc = sample_div_r + 8'd1;
    // two-bit vertical counter
    change  = key_r ^ op.pressed;
    vl_n    = ~(vert_low_r & change);
    vh_n    = vl_n ^ (vert_high_r & change);
    flip    = change & vl_n & vh_n;
    key_n   = key_r ^ flip;
    rc_base = key_n ? repeat_count_r : repeat_delay_r;
    rc_dec  = rc_base - 8'd1;
  end

  always_comb begin
    last_phase_nxt   = last_phase_r;
    step_accum_nxt   = step_accum_r;
    sample_div_nxt   = sample_div_r;
    vert_low_nxt     = vert_low_r;
    vert_high_nxt    = vert_high_r;
    key_nxt          = key_r;
    press_latch_nxt  = press_latch_r;
    repeat_latch_nxt = repeat_latch_r;
    repeat_count_nxt = repeat_count_r;
    res_push         = 1'b0;
    res              = '0;
    if (exec) begin
      unique case (op.cmd)
        jwk_pkg::CMD_TICK: begin
          // one-step change moves the count; two-step change is dropped
          if (diff[0]) begin
            last_phase_nxt = op.phase;
            step_accum_nxt = diff[1] ? step_accum_r + 8'd1 : step_accum_r - 8'd1;
          end
          if (div_inc == debounce_divide_r) begin
            sample_div_nxt  = 8'd0;
            vert_low_nxt    = vl_n;
            vert_high_nxt   = vh_n;
            key_nxt         = key_n;
            press_latch_nxt = press_latch_r | (key_n & flip);
            if (rc_dec == 8'd0) begin
              repeat_count_nxt = repeat_period_r;
              repeat_latch_nxt = repeat_latch_r | key_n;
            end else begin
              repeat_count_nxt = rc_dec;
            end
          end else begin
            sample_div_nxt = div_inc;
          end
        end
        jwk_pkg::CMD_STEPS: begin
          res_push        = 1'b1;
          res.steps_moved = $signed(step_accum_r[7:1]);
          step_accum_nxt  = {7'd0, step_accum_r[0]};
        end
        jwk_pkg::CMD_PRESS: begin
          res_push        = 1'b1;
          res.button_flag = press_latch_r;
          press_latch_nxt = 1'b0;
        end
        jwk_pkg::CMD_REPEAT: begin
          res_push         = 1'b1;
          res.button_flag  = repeat_latch_r;
          repeat_latch_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_divide_r <= jwk_pkg::DEBOUNCE_DIVIDE_RST;
      repeat_delay_r    <= jwk_pkg::REPEAT_DELAY_RST;
      repeat_period_r   <= jwk_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jwk_pkg::CFG_DEBOUNCE_DIVIDE: debounce_divide_r <= cfg_data;
        jwk_pkg::CFG_REPEAT_DELAY:    repeat_delay_r    <= cfg_data;
        jwk_pkg::CFG_REPEAT_PERIOD:   repeat_period_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r   <= 2'd0;
      step_accum_r   <= 8'd0;
      sample_div_r   <= 8'd0;
      vert_low_r     <= 1'b0;
      vert_high_r    <= 1'b0;
      key_r          <= 1'b0;
      press_latch_r  <= 1'b0;
      repeat_latch_r <= 1'b0;
      repeat_count_r <= 8'd0;
    end else begin
      last_phase_r   <= last_phase_nxt;
      step_accum_r   <= step_accum_nxt;
      sample_div_r   <= sample_div_nxt;
      vert_low_r     <= vert_low_nxt;
      vert_high_r    <= vert_high_nxt;
      key_r          <= key_nxt;
      press_latch_r  <= press_latch_nxt;
      repeat_latch_r <= repeat_latch_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

endmodule

// ===== hdl/jwk_outq.sv =====
// Result queue: 2-entry queue between the back end and the result ports.
// Depends on jwk_pkg.
`timescale 1ns / 1ps

module jwk_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  jwk_pkg::result_t    res,
  output logic                res_full,
  input  logic                out_pop,
  output logic                out_empty,
  output logic signed [6:0]   out_steps_moved,
  output logic                out_button_flag
);

  jwk_pkg::result_t mem_r [2];
  jwk_pkg::result_t head;
  logic [1:0]       count_r, count_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign res_full        = (count_r == 2'd2);
  assign out_empty       = (count_r == 2'd0);
  assign head            = mem_r[rd_ptr_r];
  assign out_steps_moved = head.steps_moved;
  assign out_button_flag = head.button_flag;
  assign do_push         = res_push && !res_full;
  assign do_pop          = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== bench/jwk_checker.sv =====
// Scoreboard for the jog wheel core: snoops config writes and both item channels,
// predicts each read result, and checks it against the out_ ports. Depends on jwk_pkg.
`timescale 1ns / 1ps

module jwk_checker
  import jwk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [1:0]        in_command,
  input  logic              in_pin_a,
  input  logic              in_pin_b,
  input  logic              in_pin_button,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic signed [6:0] out_steps_moved,
  input  logic              out_button_flag,
  output int                fail_count,
  output int                pending,
  output int                checked
);

  // shadow registers
  logic [7:0] div_reg, dly_reg, per_reg;

  // shadow state
  logic [1:0] wheel_phase;
  logic [7:0] step_count;
  logic [7:0] tick_divider;
  logic [7:0] repeat_left;
  logic       vote_lo, vote_hi;
  logic       key_down;
  logic       press_seen, repeat_seen;

  result_t expected_results[$];

  // one debounce sample through the two-bit vertical counter
  task automatic sample_key(input logic pressed);
    logic flip;
    flip    = key_down ^ pressed;
    vote_lo = ~(vote_lo & flip);
    vote_hi = vote_lo ^ (vote_hi & flip);
    flip    = flip & vote_lo & vote_hi;
    key_down   = key_down ^ flip;
    press_seen = press_seen | (key_down & flip);
    if (!key_down)
      repeat_left = dly_reg;
    repeat_left = repeat_left - 8'd1;
    if (repeat_left == 8'd0) begin
      repeat_left = per_reg;
      repeat_seen = repeat_seen | key_down;
    end
  endtask

  task automatic advance_tick(input logic a, input logic b, input logic btn);
    logic [1:0] phase;
    logic [1:0] delta;
    phase = {a, a ^ b};
    delta = wheel_phase - phase;
    if (delta[0]) begin
      wheel_phase = phase;
      step_count  = step_count + (delta[1] ? 8'd1 : 8'hFF);
    end
    tick_divider = tick_divider + 8'd1;
    if (tick_divider == div_reg) begin
      tick_divider = 8'd0;
      sample_key(~btn);
    end
  endtask

  function automatic result_t answer_read(input cmd_t cmd);
    result_t r;
    r = '0;
    case (cmd)
      CMD_STEPS: begin
        r.steps_moved = step_count[7:1];
        step_count    = {7'd0, step_count[0]};
      end
      CMD_PRESS: begin
        r.button_flag = press_seen;
        press_seen    = 1'b0;
      end
      default: begin
        r.button_flag = repeat_seen;
        repeat_seen   = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      div_reg      = DEBOUNCE_DIVIDE_RST;
      dly_reg      = REPEAT_DELAY_RST;
      per_reg      = REPEAT_PERIOD_RST;
      wheel_phase  = '0;
      step_count   = '0;
      tick_divider = '0;
      repeat_left  = '0;
      vote_lo      = 1'b0;
      vote_hi      = 1'b0;
      key_down     = 1'b0;
      press_seen   = 1'b0;
      repeat_seen  = 1'b0;
      expected_results.delete();
      fail_count   = 0;
      checked      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE_DIVIDE: div_reg = cfg_data;
          CFG_REPEAT_DELAY:    dly_reg = cfg_data;
          CFG_REPEAT_PERIOD:   per_reg = cfg_data;
          default: ;
        endcase
      end

      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: steps_moved %0d button_flag %0b",
                 out_steps_moved, out_button_flag);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_steps_moved !== want.steps_moved) begin
            $error("steps_moved: expected %0d, actual %0d", want.steps_moved,
                   out_steps_moved);
            fail_count++;
          end
          if (out_button_flag !== want.button_flag) begin
            $error("button_flag: expected %0b, actual %0b", want.button_flag,
                   out_button_flag);
            fail_count++;
          end
        end
      end

      if (in_push && !in_full) begin
        if (cmd_t'(in_command) == CMD_TICK)
          advance_tick(in_pin_a, in_pin_b, in_pin_button);
        else
          expected_results.push_back(answer_read(cmd_t'(in_command)));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the jog wheel core testbench: clock, reset, stimulus and verdict.
// Depends on jwk_pkg, jog_wheel_encoder_and_key_core and jwk_checker.
`timescale 1ns / 1ps

module tb_top;
  import jwk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_command;
  logic              in_pin_a;
  logic              in_pin_b;
  logic              in_pin_button;
  logic              out_empty;
  logic              out_pop;
  logic signed [6:0] out_steps_moved;
  logic              out_button_flag;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  int cycles = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int reads_sent = 0;
  int settings = 1;    // reset values count as the first setting
  int burst_left = 0;

  // jog wheel model: binary phase, spin direction and button run
  logic [1:0] wheel = 2'd0;
  logic [1:0] spin = 2'd1;
  logic       key_level = 1'b1;  // pin level, 1 = released
  int         key_run = 0;
  int         tick_span = 10;    // ticks per button sample at the current divider

  jog_wheel_encoder_and_key_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_pin_a        (in_pin_a),
    .in_pin_b        (in_pin_b),
    .in_pin_button   (in_pin_button),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_steps_moved (out_steps_moved),
    .out_button_flag (out_button_flag)
  );

  jwk_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_pin_a        (in_pin_a),
    .in_pin_b        (in_pin_b),
    .in_pin_button   (in_pin_button),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_steps_moved (out_steps_moved),
    .out_button_flag (out_button_flag),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL jog_wheel_encoder_and_key_core");
      $finish;
    end
  end

  // Result side: pop behavior switches at random between modes:
  // always ready, coin flip, a regular beat, and long stalls.
  initial begin
    int hold;
    int mode;
    int beat;
    hold = 0;
    mode = 0;
    beat = 0;
    out_pop <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(16, 96);
      end
      hold--;
      beat++;
      case (mode)
        0:       out_pop <= 1'b1;
        1:       out_pop <= 1'($urandom_range(0, 1));
        2:       out_pop <= (beat % 4 == 0);
        default: out_pop <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Entered and left just after a falling edge. in_push stays high after
  // acceptance so the next item can follow back to back; callers lower it
  // before any other pause; the task lowers it itself for its random gaps.
  task automatic send_item(input cmd_t cmd, input logic a, input logic b,
                           input logic btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_push       <= 1'b1;
    in_command    <= cmd;
    in_pin_a      <= a;
    in_pin_b      <= b;
    in_pin_button <= btn;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    items_sent++;
    if (cmd == CMD_TICK)
      ticks_sent++;
    else
      reads_sent++;
  endtask

  // Hold off until every read has been answered, then let the tick pipeline
  // settle (results show in the cycle after their item is taken).
  task automatic drain();
    in_push <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Only called while idle.
  task automatic set_regs(input logic [7:0] div, input logic [7:0] dly,
                          input logic [7:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_DIVIDE;
    cfg_data  <= div;
    @(negedge clk);
    cfg_index <= CFG_REPEAT_DELAY;
    cfg_data  <= dly;
    @(negedge clk);
    cfg_index <= CFG_REPEAT_PERIOD;
    cfg_data  <= per;
    @(negedge clk);
    cfg_we <= 1'b0;
    tick_span = (div == 8'd0) ? 256 : int'(div);
    settings++;
  endtask

  // Mostly well-formed jog activity: single Gray steps in a running direction,
  // button held or released over whole debounce windows. Some noise: skipped
  // phases, contact bounce, short button blips, and reads with junk pins.
  task automatic jog_item();
    int   r;
    logic btn;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_item(cmd_t'($urandom_range(1, 3)), 1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      if (key_run == 0) begin
        key_level = ~key_level;
        key_run = (($urandom_range(0, 9) < 3) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 30)) * tick_span;
      end
      key_run--;
      btn = key_level;
      if ($urandom_range(0, 19) == 0)
        btn = ~btn;
      r = $urandom_range(0, 19);
      if (r < 9)
        wheel = wheel + spin;
      else if (r == 9)
        spin = -spin;
      else if (r == 10)
        wheel = wheel + 2'd2;
      // Gray encode: A is the phase msb, B is msb ^ lsb
      send_item(CMD_TICK, wheel[1], wheel[1] ^ wheel[0], btn);
    end
  endtask

  task automatic jog_run(input int count);
    repeat (count) jog_item();
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_DEBOUNCE_DIVIDE;
    cfg_data      <= 8'd0;
    in_push       <= 1'b0;
    in_command    <= CMD_TICK;
    in_pin_a      <= 1'b0;
    in_pin_b      <= 1'b0;
    in_pin_button <= 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values
    jog_run(50);
    drain();

    // Directed: fast debounce so the button reaches press and repeat quickly.
    set_regs(8'd1, 8'd3, 8'd1);
    wheel = 2'd0;
    send_item(CMD_STEPS,  1'b0, 1'b0, 1'b1);  // reads what the earlier jog run left
    send_item(CMD_PRESS,  1'b1, 1'b1, 1'b0);
    send_item(CMD_REPEAT, 1'b0, 1'b1, 1'b1);
    send_item(CMD_TICK,   1'b1, 1'b0, 1'b1);  // step down from zero wraps
    send_item(CMD_STEPS,  1'b0, 1'b0, 1'b0);  // halved read of the wrapped count
    send_item(CMD_TICK,   1'b1, 1'b1, 1'b0);
    send_item(CMD_TICK,   1'b0, 1'b1, 1'b0);
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   1'b1, 1'b1, 1'b0);  // two-step jump is ignored
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   1'b0, 1'b1, 1'b0);  // step up
    send_item(CMD_TICK,   1'b1, 1'b1, 1'b0);
    send_item(CMD_PRESS,  1'b0, 1'b0, 1'b0);
    send_item(CMD_REPEAT, 1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   1'b1, 1'b0, 1'b0);
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b0);
    send_item(CMD_REPEAT, 1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b1);  // release
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b1);
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b1);
    send_item(CMD_TICK,   1'b0, 1'b0, 1'b1);
    send_item(CMD_STEPS,  1'b1, 1'b1, 1'b1);
    send_item(CMD_PRESS,  1'b1, 1'b1, 1'b1);
    send_item(CMD_REPEAT, 1'b1, 1'b1, 1'b1);
    wheel = 2'd0;
    jog_run(50);
    drain();

    // low extremes
    set_regs(8'd1, 8'd1, 8'd1);
    jog_run(50);
    drain();

    // high extremes: button sampled rarely
    set_regs(8'd255, 8'd255, 8'd255);
    jog_run(30);
    drain();

    set_regs(8'd2, 8'd5, 8'd3);
    jog_run(50);
    drain();

    // Divider dropped below its running count, to zero: the count runs on
    // through the wrap before the next sample. Repeat registers at zero
    // make the repeat count wrap on decrement.
    set_regs(8'd200, 8'd0, 8'd0);
    jog_run(40);
    drain();
    set_regs(8'd0, 8'd0, 8'd0);
    jog_run(240);
    drain();

    set_regs(8'd1, 8'd0, 8'd0);
    jog_run(30);
    drain();

    repeat (20) @(negedge clk);
    $display("Covered %0d items (%0d ticks, %0d reads) over %0d register settings.",
             items_sent, ticks_sent, reads_sent, settings);
    $display("Checked %0d result items, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("PASS jog_wheel_encoder_and_key_core");
    else
      $display("FAIL jog_wheel_encoder_and_key_core");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jwk_pkg.sv
hdl/jwk_front.sv
hdl/jwk_back.sv
hdl/jwk_outq.sv
hdl/jog_wheel_encoder_and_key_core.sv
bench/jwk_checker.sv
bench/tb_top.sv
